// ===== hdl/kcl_pkg.sv =====
package kcl_pkg;

  localparam int unsigned RAW_W   = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned STAR_W  = 3;

  localparam logic [RAW_W-1:0] KEY_ENTER   = 8'd16;
  localparam logic [RAW_W-1:0] KEY_NEWCODE = 8'd15;
  localparam logic [RAW_W-1:0] DIGIT_LIMIT = 8'd10;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DIGIT    = 3'd1,
    EV_UNLOCKED = 3'd2,
    EV_WRONG    = 3'd3,
    EV_CHANGED  = 3'd4,
    EV_PROMPT   = 3'd5
  } event_t;

  typedef struct packed {
    event_t              event_res;
    logic [STAR_W-1:0]   star_count;
    logic                beep;
    logic                is_unlocked;
  } result_t;

  // Scan code to key value; unlisted codes pass through unchanged.
  function automatic logic [RAW_W-1:0] map_key(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] key;
    unique case (raw)
      8'd6:    key = 8'd1;
      8'd5:    key = 8'd2;
      8'd4:    key = 8'd3;
      8'd3:    key = 8'd13;
      8'd14:   key = 8'd4;
      8'd13:   key = 8'd5;
      8'd12:   key = 8'd6;
      8'd11:   key = 8'd14;
      8'd22:   key = 8'd7;
      8'd21:   key = 8'd8;
      8'd20:   key = 8'd9;
      8'd19:   key = 8'd15;
      8'd30:   key = 8'd11;
      8'd29:   key = 8'd0;
      8'd28:   key = 8'd12;
      8'd27:   key = 8'd16;
      default: key = raw;
    endcase
    return key;
  endfunction

endpackage

// ===== hdl/kcl_core.sv =====
module kcl_core #(
  parameter int unsigned CODE_LENGTH = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [kcl_pkg::RAW_W-1:0]     raw_key_code,
  output kcl_pkg::result_t              result
);

  localparam int unsigned POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned CNT_W = POS_W + 1;

  logic [kcl_pkg::DIGIT_W-1:0] entered_digits [CODE_LENGTH];
  logic [kcl_pkg::DIGIT_W-1:0] stored_code    [CODE_LENGTH];
  logic [POS_W-1:0]            entry_position;
  logic [POS_W-1:0]            entry_position_next;
  logic                        unlocked_flag;
  logic                        unlocked_flag_next;

  logic [kcl_pkg::RAW_W-1:0]   key;
  logic                        is_digit;
  logic                        code_match;
  logic                        digit_wr;
  logic                        code_wr;
  logic [CNT_W-1:0]            count;

  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entered_digits[i] != stored_code[i]) begin
        code_match = 1'b0;
      end
    end
  end

  always_comb begin
    key                 = kcl_pkg::map_key(raw_key_code);
    is_digit            = key < kcl_pkg::DIGIT_LIMIT;
    count               = {1'b0, entry_position} + CNT_W'(1);
    entry_position_next = entry_position;
    unlocked_flag_next  = unlocked_flag;
    digit_wr            = 1'b0;
    code_wr             = 1'b0;
    result.event_res    = kcl_pkg::EV_NONE;
    result.star_count   = '0;
    result.beep         = 1'b0;

    if (is_digit) begin
      digit_wr          = 1'b1;
      result.event_res  = kcl_pkg::EV_DIGIT;
      result.star_count = kcl_pkg::STAR_W'(count);
      // wrap once the full code length is in
      if (count == CNT_W'(CODE_LENGTH)) begin
        entry_position_next = '0;
      end else begin
        entry_position_next = POS_W'(count);
      end
    end else if (key == kcl_pkg::KEY_ENTER) begin
      if (!unlocked_flag) begin
        if (code_match) begin
          unlocked_flag_next = 1'b1;
          result.event_res   = kcl_pkg::EV_UNLOCKED;
        end else begin
          entry_position_next = '0;
          result.beep         = 1'b1;
          result.event_res    = kcl_pkg::EV_WRONG;
        end
      end else begin
        code_wr            = 1'b1;
        unlocked_flag_next = 1'b0;
        result.event_res   = kcl_pkg::EV_CHANGED;
      end
    end else if (key == kcl_pkg::KEY_NEWCODE && unlocked_flag) begin
      result.event_res = kcl_pkg::EV_PROMPT;
    end

    result.is_unlocked = unlocked_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position <= '0;
      unlocked_flag  <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        entered_digits[i] <= '0;
        stored_code[i]    <= kcl_pkg::DIGIT_W'(i % 10);
      end
    end else if (fire) begin
      entry_position <= entry_position_next;
      unlocked_flag  <= unlocked_flag_next;
      if (digit_wr) begin
        entered_digits[entry_position] <= key[kcl_pkg::DIGIT_W-1:0];
      end
      if (code_wr) begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
          stored_code[i] <= entered_digits[i];
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, entry_position} < CNT_W'(CODE_LENGTH))
    else $error("entry position beyond code length");

  a_wrong_resets_pos: assert property (@(posedge clk) disable iff (rst)
    fire && result.event_res == kcl_pkg::EV_WRONG |=> entry_position == '0)
    else $error("wrong code did not reset position");

  a_unlock_sets_flag: assert property (@(posedge clk) disable iff (rst)
    fire && result.event_res == kcl_pkg::EV_UNLOCKED |=> unlocked_flag)
    else $error("unlock event without unlocked state");

  a_change_locks: assert property (@(posedge clk) disable iff (rst)
    fire && result.event_res == kcl_pkg::EV_CHANGED |=>
      !unlocked_flag && stored_code[0] == $past(entered_digits[0]))
    else $error("code change did not lock and store");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(unlocked_flag) && $stable(entry_position))
    else $error("lock state moved without a request");
`endif

endmodule

// ===== hdl/keypad_code_lock.sv =====
// Path from input request to result: input register, then result register.
// Throughput: one request per cycle; s_tready stays high while the result
// register is empty or being drained.
// The key map, digit buffer and code compare sit between the two registers.
// Reset (rst, synchronous, active high) locks, clears the entry buffer and
// position, and loads the stored code with digits 0,1,2,... (i mod 10).
module keypad_code_lock #(
  parameter int unsigned CODE_LENGTH = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] raw_key_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] event_res, [5:3] star_count, [6] beep, [7] is_unlocked
);

  logic                         in_valid;
  logic [kcl_pkg::RAW_W-1:0]    in_code;
  logic                         out_free;
  logic                         fire;
  kcl_pkg::result_t             result;
  kcl_pkg::result_t             out_res;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_code <= s_tdata;
    end
  end

  kcl_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .raw_key_code (in_code),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tdata = {out_res.is_unlocked, out_res.beep, out_res.star_count,
                    out_res.event_res};

endmodule

// ===== dv/keypad_code_lock_test.sv =====
module keypad_code_lock_test;

  localparam int CODE_LEN     = 5;
  localparam int RANDOM_KEYS  = 750;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 40;

  localparam logic [7:0] RAW_ENTER_ALT  = 8'd27;
  localparam logic [7:0] RAW_PROMPT_ALT = 8'd19;

  // Scan codes that the keypad remaps, and the key each one becomes (same slot).
  localparam logic [127:0] REMAP_FROM = {
    8'd6, 8'd5, 8'd4, 8'd3, 8'd14, 8'd13, 8'd12, 8'd11,
    8'd22, 8'd21, 8'd20, 8'd19, 8'd30, 8'd29, 8'd28, 8'd27
  };
  localparam logic [127:0] REMAP_TO = {
    8'd1, 8'd2, 8'd3, 8'd13, 8'd4, 8'd5, 8'd6, 8'd14,
    8'd7, 8'd8, 8'd9, 8'd15, 8'd11, 8'd0, 8'd12, 8'd16
  };

  typedef struct packed {
    kcl_pkg::event_t ev;
    logic [2:0]      stars;
    logic            beep;
    logic            unl;
  } lock_result_t;

  // typed rows carry their own expectation; the rest go through the lock model
  typedef struct packed {
    logic [7:0]   raw;
    logic         typed;
    lock_result_t want;
  } key_row_t;

  key_row_t dir_rows [25] = '{
    {8'd16,  1'b1, kcl_pkg::EV_WRONG,    3'd0, 1'b1, 1'b0},
    {8'd15,  1'b1, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd255, 1'b1, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd0,   1'b1, kcl_pkg::EV_DIGIT,    3'd1, 1'b0, 1'b0},
    {8'd1,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd2,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd4,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd14,  1'b1, kcl_pkg::EV_DIGIT,    3'd5, 1'b0, 1'b0},
    {8'd27,  1'b1, kcl_pkg::EV_UNLOCKED, 3'd0, 1'b0, 1'b1},
    {8'd19,  1'b1, kcl_pkg::EV_PROMPT,   3'd0, 1'b0, 1'b1},
    {8'd3,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd7,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd8,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd9,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd29,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd16,  1'b1, kcl_pkg::EV_CHANGED,  3'd0, 1'b0, 1'b0},
    {8'd128, 1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd10,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd11,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd30,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd28,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd27,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd16,  1'b1, kcl_pkg::EV_CHANGED,  3'd0, 1'b0, 1'b0},
    {8'd21,  1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0},
    {8'd6,   1'b0, kcl_pkg::EV_NONE,     3'd0, 1'b0, 1'b0}
  };

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  // lock model state
  logic [3:0] entry_buf [CODE_LEN];
  logic [3:0] lock_code [CODE_LEN];
  int         entry_pos;
  logic       is_open;

  lock_result_t pending_results [$];
  logic         cur_typed = 1'b0;
  lock_result_t cur_want;

  int keys_sent, results_seen, mismatches;
  int opens, refusals, code_changes, prompts;
  int  send_pace = 0;
  bit  send_eager = 0;

  keypad_code_lock dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] scan_key(input logic [7:0] raw);
    logic [7:0] key;
    key = raw;
    for (int i = 0; i < 16; i++)
      if (REMAP_FROM[i*8 +: 8] == raw) key = REMAP_TO[i*8 +: 8];
    return key;
  endfunction

  // Pick a scan code for a digit, the pass-through one or the remapped one.
  function automatic logic [7:0] digit_scan(input logic [3:0] d);
    logic [7:0] raw;
    raw = {4'd0, d};
    if (scan_key(raw) == raw && $urandom_range(0, 1) == 1) return raw;
    for (int i = 0; i < 16; i++)
      if (REMAP_TO[i*8 +: 8] == raw) return REMAP_FROM[i*8 +: 8];
    return raw;
  endfunction

  function automatic logic [7:0] enter_scan();
    return ($urandom_range(0, 1) == 1) ? kcl_pkg::KEY_ENTER : RAW_ENTER_ALT;
  endfunction

  task automatic predict_lock(input logic [7:0] raw, output lock_result_t r);
    logic [7:0] key;
    bit         same;
    key = scan_key(raw);
    r = '{kcl_pkg::EV_NONE, 3'd0, 1'b0, 1'b0};
    if (key < kcl_pkg::DIGIT_LIMIT) begin
      entry_buf[entry_pos] = key[3:0];
      entry_pos++;
      r.stars = entry_pos[2:0];
      if (entry_pos >= CODE_LEN) entry_pos = 0;
      r.ev = kcl_pkg::EV_DIGIT;
    end else if (key == kcl_pkg::KEY_ENTER) begin
      if (!is_open) begin
        same = 1;
        for (int i = 0; i < CODE_LEN; i++)
          if (entry_buf[i] != lock_code[i]) same = 0;
        if (same) begin
          is_open = 1'b1;
          r.ev = kcl_pkg::EV_UNLOCKED;
        end else begin
          entry_pos = 0;
          r.beep = 1'b1;
          r.ev = kcl_pkg::EV_WRONG;
        end
      end else begin
        // store whatever the buffer holds, position untouched
        for (int i = 0; i < CODE_LEN; i++) lock_code[i] = entry_buf[i];
        is_open = 1'b0;
        r.ev = kcl_pkg::EV_CHANGED;
      end
    end else if (key == kcl_pkg::KEY_NEWCODE && is_open) begin
      r.ev = kcl_pkg::EV_PROMPT;
    end
    r.unl = is_open;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("ERROR result %0d: %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  initial begin
    for (int i = 0; i < CODE_LEN; i++) begin
      entry_buf[i] = 4'd0;
      lock_code[i] = 4'(i % 10);
    end
    entry_pos = 0;
    is_open = 1'b0;
  end

  always @(posedge clk) begin
    lock_result_t pred, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_lock(s_tdata, pred);
        case (pred.ev)
          kcl_pkg::EV_UNLOCKED: opens++;
          kcl_pkg::EV_WRONG:    refusals++;
          kcl_pkg::EV_CHANGED:  code_changes++;
          kcl_pkg::EV_PROMPT:   prompts++;
          default: ;
        endcase
        pending_results.push_back(cur_typed ? cur_want : pred);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", m_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[2:0] != want.ev)    report_mismatch("event_res", m_tdata[2:0], want.ev);
          if (m_tdata[5:3] != want.stars) report_mismatch("star_count", m_tdata[5:3], want.stars);
          if (m_tdata[6] != want.beep)    report_mismatch("beep", m_tdata[6], want.beep);
          if (m_tdata[7] != want.unl)     report_mismatch("is_unlocked", m_tdata[7], want.unl);
        end
      end
    end
  end

  // Result side: stall at random, with stretches of constant ready.
  initial begin
    int stall, pace;
    bit eager;
    pace = 0;
    eager = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (pace == 0) begin
        eager = ($urandom_range(0, 2) == 0);
        pace = $urandom_range(20, 60);
      end
      pace--;
      stall = eager ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_key(input logic [7:0] raw);
    int gap;
    if (send_pace == 0) begin
      send_eager = ($urandom_range(0, 2) == 0);
      send_pace = $urandom_range(20, 60);
    end
    send_pace--;
    gap = send_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= raw;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    keys_sent++;
    @(negedge clk);
  endtask

  initial begin
    key_row_t row;
    int       ep, n, start;
    bit       held;
    held = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      cur_typed = row.typed;
      cur_want = row.want;
      send_key(row.raw);
    end
    cur_typed = 1'b0;

    while (keys_sent < RANDOM_KEYS + $size(dir_rows)) begin
      ep = $urandom_range(0, 9);
      if (ep <= 5) begin
        // correct code from wherever the position stands, then open and rekey
        if (!is_open) begin
          if ($urandom_range(0, 7) == 0) send_key(8'($urandom_range(0, 255)));
          start = entry_pos;
          for (int k = 0; k < CODE_LEN; k++)
            send_key(digit_scan(lock_code[(start + k) % CODE_LEN]));
          send_key(enter_scan());
        end
        if (is_open) begin
          if ($urandom_range(0, 1) == 1)
            send_key(($urandom_range(0, 1) == 1) ? kcl_pkg::KEY_NEWCODE : RAW_PROMPT_ALT);
          n = $urandom_range(0, 7);
          for (int k = 0; k < n; k++) send_key(digit_scan(4'($urandom_range(0, 9))));
          if ($urandom_range(0, 5) == 0) send_key(8'($urandom_range(0, 255)));
          send_key(enter_scan());
        end
      end else if (ep <= 7) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) send_key(digit_scan(4'($urandom_range(0, 9))));
        send_key(enter_scan());
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) send_key(8'($urandom_range(0, 255)));
      end
      // hold the sender once until the result side has caught up
      if (!held && keys_sent >= RANDOM_KEYS / 2) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        held = 1;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key requests (%0d directed), checked %0d results.",
             keys_sent, $size(dir_rows), results_seen);
    $display("Lock opened %0d times, refused %0d codes, took %0d new codes, prompted %0d times.",
             opens, refusals, code_changes, prompts);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kcl_pkg.sv
hdl/kcl_core.sv
hdl/keypad_code_lock.sv
dv/keypad_code_lock_test.sv
